// File: hw/rtl/mbpe_pkg.sv
// ----------------------------------------------------------------------------
// mbpe_pkg
// Shared types and constants for the monochrome bitmap pixel expander.
// ----------------------------------------------------------------------------
`default_nettype none

package mbpe_pkg;

    localparam int unsigned MAX_DIM   = 1024;
    localparam int unsigned DIM_W     = 11;   // image_width / image_height / row
    localparam int unsigned COL_W     = 8;    // byte column, holds MAX_DIM / 8
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned COLOR_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);

    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_FG_COLOR     = 3'd4,
        REG_BG_COLOR     = 3'd5,
        REG_OPAQUE_MODE  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic               opaque_mode;
    } cfg_t;

    // One queued byte: base coordinates, pixel bits and the bits to draw.
    // Bit j of data/mask is pixel column 7-j within the byte.
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y;
        logic [7:0]         data;
        logic [7:0]         mask;
    } job_t;

    // Index of the highest set bit (leftmost pixel still to draw).
    function automatic logic [2:0] top_bit(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) idx = 3'(i);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mono_bitmap_pixel_expander_top.sv
// ----------------------------------------------------------------------------
// mono_bitmap_pixel_expander_top
// Expands a 1-bit, MSB-first, row-padded bitmap byte stream into pixel writes.
// ----------------------------------------------------------------------------
//  port group  dir  payload
//  s_*         in   s_tdata[7:0] = bitmap_byte
//  m_*         out  m_tdata = pixel_x, pixel_y, pixel_color; m_tlast = last_of_byte
//  cfg_*       in   cfg_index selects register, cfg_wdata holds its value
//
//  A byte yields 0 to 8 pixel writes, one per cycle from the back end while
//  the output is not stalled; the back end walks the byte's draw mask
//  serially. Bytes that draw nothing are accepted but never enter the queue.
//  A four-entry job queue lets input and output stall independently.
//  Reset (aresetn low, synchronous) clears counters, queue and registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_bitmap_pixel_expander_top
    import mbpe_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] bitmap_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [47:0]                m_tdata,   // [15:0] pixel_x, [31:16] pixel_y,
                                                  // [47:32] pixel_color
    output logic                       m_tlast    // last_of_byte
);

    cfg_t cfg_reg, cfg_next;
    logic q_full, q_push, q_pop, q_nonempty;
    job_t q_job, q_head;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_ORIGIN_X:     cfg_next.origin_x     = cfg_wdata;
                REG_ORIGIN_Y:     cfg_next.origin_y     = cfg_wdata;
                REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_wdata[DIM_W-1:0];
                REG_FG_COLOR:     cfg_next.fg_color     = cfg_wdata;
                REG_BG_COLOR:     cfg_next.bg_color     = cfg_wdata;
                REG_OPAQUE_MODE:  cfg_next.opaque_mode  = cfg_wdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) cfg_reg <= '0;
        else          cfg_reg <= cfg_next;
    end

    mbpe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    mbpe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    mbpe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// File: hw/rtl/mbpe_front.sv
// ----------------------------------------------------------------------------
// mbpe_front
// Accepts bitmap bytes, tracks byte column and row, builds a draw job.
// ----------------------------------------------------------------------------
`default_nettype none

module mbpe_front
    import mbpe_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       q_full,
    output logic            q_push,
    output job_t            q_job
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;

    logic [DIM_W-1:0] w, h;
    logic [COL_W-1:0] row_bytes;
    logic [COL_W-1:0] col_eff, col_inc;
    logic [DIM_W-1:0] row_eff, row_inc;
    logic [DIM_W-1:0] col_px, remain;
    logic [3:0]       valid_cnt;
    logic [7:0]       vmask, dmask;
    logic             empty_img, accept;

    always_comb begin
        w = (cfg.image_width  > MAX_DIM_V) ? MAX_DIM_V : cfg.image_width;
        h = (cfg.image_height > MAX_DIM_V) ? MAX_DIM_V : cfg.image_height;
        empty_img = (w == '0) || (h == '0);
        row_bytes = COL_W'((w + DIM_W'(7)) >> 3);

        // restart if a register change left the counters outside the image
        if ((col_reg >= row_bytes) || (row_reg >= h)) begin
            col_eff = '0;
            row_eff = '0;
        end else begin
            col_eff = col_reg;
            row_eff = row_reg;
        end

        col_px = {col_eff, 3'b000};
        remain = w - col_px;
        valid_cnt = (remain >= DIM_W'(8)) ? 4'd8 : remain[3:0];
        vmask = ~(8'hFF >> valid_cnt);
        dmask = vmask & (s_tdata | {8{cfg.opaque_mode}});

        col_inc = col_eff + COL_W'(1);
        row_inc = row_eff + DIM_W'(1);
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (empty_img) begin
                col_next = '0;
                row_next = '0;
            end else if (col_inc >= row_bytes) begin
                col_next = '0;
                row_next = (row_inc >= h) ? '0 : row_inc;
            end else begin
                col_next = col_inc;
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign q_push     = accept && !empty_img && (dmask != 8'h00);
    assign q_job.x0   = cfg.origin_x + COORD_W'(col_px);
    assign q_job.y    = cfg.origin_y + COORD_W'(row_eff);
    assign q_job.data = s_tdata;
    assign q_job.mask = dmask;

endmodule

`default_nettype wire

// File: hw/rtl/mbpe_queue.sv
// ----------------------------------------------------------------------------
// mbpe_queue
// Small job FIFO between the byte front end and the pixel back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mbpe_queue
    import mbpe_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      nonempty,
    output job_t      head
);

    job_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full     = (cnt_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign head     = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) cnt_next = cnt_reg + (Q_PTR_W+1)'(1);
        else if (do_pop && !do_push) cnt_next = cnt_reg - (Q_PTR_W+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mbpe_back.sv
// ----------------------------------------------------------------------------
// mbpe_back
// Walks the draw mask of each job, one pixel write per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbpe_back
    import mbpe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        q_nonempty,
    input  wire job_t        q_head,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,
    output logic             m_tlast
);

    logic               cur_valid_reg, cur_valid_next;
    job_t               cur_reg, cur_next;
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] out_x_reg, out_x_next;
    logic [COORD_W-1:0] out_y_reg, out_y_next;
    logic [COLOR_W-1:0] out_c_reg, out_c_next;
    logic               out_l_reg, out_l_next;

    logic       out_free, emit, done;
    logic [2:0] j;
    logic [7:0] rem;

    always_comb begin
        out_free = !out_valid_reg || m_tready;
        emit     = cur_valid_reg && out_free;
        j        = top_bit(cur_reg.mask);
        rem      = cur_reg.mask & ~(8'h01 << j);
        done     = emit && (rem == 8'h00);
        q_pop    = q_nonempty && (!cur_valid_reg || done);

        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        if (emit) cur_next.mask = rem;
        if (done) cur_valid_next = 1'b0;
        if (q_pop) begin
            cur_valid_next = 1'b1;
            cur_next       = q_head;
        end

        out_valid_next = out_valid_reg && !m_tready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_c_next     = out_c_reg;
        out_l_next     = out_l_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            // pixel column within the byte is 7 - j
            out_x_next = cur_reg.x0 + COORD_W'(3'd7 - j);
            out_y_next = cur_reg.y;
            out_c_next = cur_reg.data[j] ? cfg.fg_color : cfg.bg_color;
            out_l_next = (rem == 8'h00);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_c_reg <= out_c_next;
        out_l_reg <= out_l_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_c_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_l_reg;

endmodule

`default_nettype wire

// File: hw/rtl/mbpe_checker.sv
// ----------------------------------------------------------------------------
// mbpe_checker
// Port-level checks on the pixel expander, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbpe_checker
    import mbpe_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [47:0]           m_tdata,
    input wire logic                  m_tlast
);

    // stalled output holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // pixels of one byte come back to back on the same row
    a_byte_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[31:16] == $past(m_tdata[31:16])))
        else $error("byte burst broken or row changed inside byte");

    // within a byte, x moves right; this checks only that x does not repeat
    a_byte_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            (m_tdata[15:0] != $past(m_tdata[15:0])))
        else $error("repeated x inside byte");

endmodule

bind mono_bitmap_pixel_expander_top mbpe_checker u_mbpe_checker (.*);

`default_nettype wire

// File: verif/mbpe_pixel_checker.sv
// ----------------------------------------------------------------------------
// mbpe_pixel_checker
// Watches the config port and both streams of the bitmap pixel expander.
// Every accepted bitmap byte is expanded into the pixel writes it should
// cause, and each accepted pixel write is compared with the oldest of them.
// ----------------------------------------------------------------------------
`default_nettype none

module mbpe_pixel_checker
    import mbpe_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [7:0]            s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [47:0]           m_tdata,
    input  wire logic                  m_tlast,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    pixel_t           expected_pixels[$];
    cfg_t             regs;
    logic [COL_W-1:0] byte_col;
    logic [DIM_W-1:0] row_idx;
    int               error_total = 0;
    pixel_t           got;
    pixel_t           want;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic int dim_limit(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? int'(MAX_DIM) : int'(v);
    endfunction

    // Expected pixel writes for one bitmap byte; advances the byte/row counters, or clears them for an empty image.
    task automatic expand_byte(input logic [7:0] bits);
        int                 w;
        int                 h;
        int                 row_bytes;
        int                 valid;
        int                 n;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y;
        pixel_t             burst[8];
        w = dim_limit(regs.image_width);
        h = dim_limit(regs.image_height);
        if (w == 0 || h == 0) begin
            byte_col = '0;
            row_idx  = '0;
            return;
        end
        row_bytes = (w + 7) / 8;
        // a register change can leave the counters outside the new image
        if (byte_col >= row_bytes || row_idx >= h) begin
            byte_col = '0;
            row_idx  = '0;
        end
        valid = w - int'(byte_col) * 8;
        if (valid > 8) valid = 8;
        x0 = regs.origin_x + {byte_col, 3'b000};
        y  = regs.origin_y + COORD_W'(row_idx);
        n  = 0;
        for (int k = 0; k < valid; k++) begin
            if (bits[7-k] || regs.opaque_mode) begin
                burst[n].x     = x0 + COORD_W'(k);
                burst[n].y     = y;
                burst[n].color = bits[7-k] ? regs.fg_color : regs.bg_color;
                burst[n].last  = 1'b0;
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) burst[i].last = 1'b1;
            expected_pixels.push_back(burst[i]);
        end
        byte_col++;
        if (byte_col >= row_bytes) begin
            byte_col = '0;
            row_idx++;
            if (row_idx >= h) row_idx = '0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs     = '0;
            byte_col = '0;
            row_idx  = '0;
            expected_pixels.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_ORIGIN_X:     regs.origin_x     = cfg_wdata;
                    REG_ORIGIN_Y:     regs.origin_y     = cfg_wdata;
                    REG_IMAGE_WIDTH:  regs.image_width  = cfg_wdata[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: regs.image_height = cfg_wdata[DIM_W-1:0];
                    REG_FG_COLOR:     regs.fg_color     = cfg_wdata;
                    REG_BG_COLOR:     regs.bg_color     = cfg_wdata;
                    REG_OPAQUE_MODE:  regs.opaque_mode  = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) expand_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tlast};
                if (expected_pixels.size() == 0) begin
                    error_total++;
                    if (error_total <= 10)
                        $display("unexpected pixel write: x=%h y=%h color=%h last=%b",
                                 got.x, got.y, got.color, got.last);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.x !== want.x || got.y !== want.y ||
                        got.color !== want.color || got.last !== want.last) begin
                        error_total++;
                        if (error_total <= 10)
                            $display("pixel mismatch: expected x=%h y=%h color=%h last=%b, got x=%h y=%h color=%h last=%b",
                                     want.x, want.y, want.color, want.last,
                                     got.x, got.y, got.color, got.last);
                    end
                end
            end
        end
        pending    <= expected_pixels.size();
        fail_count <= error_total;
    end

endmodule

`default_nettype wire

// File: verif/tb_mono_bitmap_pixel_expander_top.sv
// ----------------------------------------------------------------------------
// tb_mono_bitmap_pixel_expander_top
// Drives bitmap bytes and register writes into the pixel expander: a short
// directed part (empty image, wrap of coordinates, transparent and opaque
// clear bits, pad bits, oversized dimensions, counters left out of range),
// then random images of random geometry. Bursty input, patterned output
// stalls; the checker module predicts and compares every pixel write.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mono_bitmap_pixel_expander_top;
    import mbpe_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 40;
    localparam int RANDOM_BYTES = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [47:0]           m_tdata;
    logic                  m_tlast;
    int                    fail_count;
    int                    pending;

    int       cycles     = 0;
    int       burst_left = 0;
    bit       valid_up   = 1'b0;
    bit [8:0] ready_tick = '0;

    mono_bitmap_pixel_expander_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    mbpe_pixel_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // pixel sink: always ready, coin flip, 3-of-8 pattern, rare stalls
    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1'b1;
        case (ready_tick[8:7])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= (ready_tick[2:0] < 3'd3);
            default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    function automatic cfg_t make_cfg(input int ox, input int oy, input int w, input int h,
                                      input int fg, input int bg, input bit op);
        cfg_t c;
        c.origin_x     = COORD_W'(ox);
        c.origin_y     = COORD_W'(oy);
        c.image_width  = DIM_W'(w);
        c.image_height = DIM_W'(h);
        c.fg_color     = COLOR_W'(fg);
        c.bg_color     = COLOR_W'(bg);
        c.opaque_mode  = op;
        return c;
    endfunction

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(posedge aclk);
    endtask

    task automatic apply_cfg(input cfg_t c);
        write_reg(REG_ORIGIN_X, c.origin_x);
        write_reg(REG_ORIGIN_Y, c.origin_y);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(c.image_width));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(c.image_height));
        write_reg(REG_FG_COLOR, c.fg_color);
        write_reg(REG_BG_COLOR, c.bg_color);
        write_reg(REG_OPAQUE_MODE, CFG_DATA_W'(c.opaque_mode));
        cfg_we <= 1'b0;
    endtask

    // One byte; the sender runs in bursts with random gaps after each.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        valid_up = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                valid_up = 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Stop input and wait until every expected pixel write is out, then let the block settle.
    task automatic drain();
        if (valid_up) begin
            s_tvalid <= 1'b0;
            valid_up = 1'b0;
        end
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        cfg_t c;
        int   sent;
        int   sel;
        int   w_eff;
        int   whole;
        int   count;
        logic [7:0] b;
        sent = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty image right after reset
        push_byte(8'hFF);
        push_byte(8'h00);

        // opaque, pad bits, x and y wrap past 0x7FFF, counters wrap to the top
        drain();
        apply_cfg(make_cfg(16'h7FFC, 16'h7FFF, 13, 2, 16'hFFFF, 16'h0000, 1'b1));
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hA5);
        push_byte(8'h5A);
        push_byte(8'h81);

        // transparent: clear bits draw nothing
        drain();
        apply_cfg(make_cfg(16'h8000, 16'h8000, 8, 1, 16'h1234, 16'hFFFF, 1'b0));
        push_byte(8'h00);
        push_byte(8'h80);
        push_byte(8'h01);

        // oversized dimensions clamp to the maximum
        drain();
        apply_cfg(make_cfg(0, 0, 2047, 2047, 16'hF800, 16'h07E0, 1'b1));
        push_byte(8'h3C);
        push_byte(8'hC3);
        push_byte(8'h0F);
        drain();
        apply_cfg(make_cfg(0, 0, 1024, 1024, 16'hF800, 16'h07E0, 1'b1));
        push_byte(8'hF0);
        push_byte(8'h55);

        // byte column left past the row, then row past the height
        drain();
        apply_cfg(make_cfg(100, -5, 40, 3, 16'h001F, 16'hAAAA, 1'b0));
        repeat (4) push_byte(8'($urandom));
        drain();
        apply_cfg(make_cfg(100, -5, 16, 3, 16'h001F, 16'hAAAA, 1'b1));
        repeat (3) push_byte(8'($urandom));
        drain();
        apply_cfg(make_cfg(100, -5, 16, 1, 16'h001F, 16'hAAAA, 1'b1));
        push_byte(8'($urandom));

        // random images, mostly whole frames with random content
        while (sent < RANDOM_BYTES) begin
            sel = $urandom_range(0, 11);
            c.image_width  = DIM_W'($urandom_range(1, 40));
            c.image_height = DIM_W'($urandom_range(1, 5));
            if (sel == 0) begin
                c.image_width = '0;
            end else if (sel == 1) begin
                c.image_height = '0;
            end else if (sel == 2) begin
                c.image_width  = DIM_W'($urandom_range(1024, 2047));
                c.image_height = DIM_W'($urandom_range(1, 2));
            end else if (sel == 3) begin
                c.image_width  = DIM_W'($urandom_range(1, 16));
                c.image_height = DIM_W'($urandom_range(1024, 2047));
            end
            c.origin_x = ($urandom_range(0, 3) == 0) ? COORD_W'(16'h7FF0 + $urandom_range(0, 31))
                                                      : COORD_W'($urandom);
            c.origin_y = ($urandom_range(0, 3) == 0) ? COORD_W'(16'h7FFE + $urandom_range(0, 3))
                                                      : COORD_W'($urandom);
            c.fg_color    = COLOR_W'($urandom);
            c.bg_color    = COLOR_W'($urandom);
            c.opaque_mode = 1'($urandom_range(0, 1));

            w_eff = (c.image_width > MAX_DIM) ? int'(MAX_DIM) : int'(c.image_width);
            if (c.image_width == 0 || c.image_height == 0) begin
                count = $urandom_range(2, 6);
            end else if (sel == 2 || sel == 3) begin
                count = $urandom_range(10, 40);
            end else begin
                whole = ((w_eff + 7) / 8) * int'(c.image_height);
                count = whole * $urandom_range(1, 2);
                if ($urandom_range(0, 3) == 0) count += $urandom_range(1, 3);
            end

            drain();
            apply_cfg(c);
            repeat (count) begin
                case ($urandom_range(0, 7))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom);
                endcase
                push_byte(b);
                // bytes into an empty image are dropped by the block
                if (c.image_width != 0 && c.image_height != 0) sent++;
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/mbpe_pkg.sv
hw/rtl/mbpe_front.sv
hw/rtl/mbpe_queue.sv
hw/rtl/mbpe_back.sv
hw/rtl/mono_bitmap_pixel_expander_top.sv
hw/rtl/mbpe_checker.sv
verif/mbpe_pixel_checker.sv
verif/tb_mono_bitmap_pixel_expander_top.sv
